/* design/dda_pkg.sv */
package dda_pkg;

    localparam int INDEX_SPACE    = 1024;
    localparam int PENDING_DEPTH  = 256;
    localparam int FRAME_SLOTS    = 2;
    localparam int RESERVED_COUNT = 3;

    // field widths
    localparam int IDX_W  = 10;
    localparam int MASK_W = 2;

    // storage widths
    localparam int SADDR_W = $clog2(INDEX_SPACE);
    localparam int FCNT_W  = $clog2(INDEX_SPACE + 1);
    localparam int NF_W    = $clog2(INDEX_SPACE + 1);
    localparam int PADDR_W = $clog2(PENDING_DEPTH);
    localparam int PCNT_W  = $clog2(PENDING_DEPTH + 1);

    // slot bits that take part in a busy mask
    localparam logic [MASK_W-1:0] SLOT_BITS = MASK_W'((1 << FRAME_SLOTS) - 1);

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_RETIRE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_FULL      = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef struct packed {
        op_t               operation;
        logic [IDX_W-1:0]  index;
        logic              retire_slot;
        logic [MASK_W-1:0] in_flight_mask;
        logic              frame_open;
        logic              current_slot;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] result_index;
        status_t          status;
    } rsp_t;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [MASK_W-1:0] mask;
    } pend_entry_t;

    localparam int PEND_W = $bits(pend_entry_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_WALK_CHECK,
        S_WALK_EVAL
    } state_t;

    typedef struct packed {
        logic accept;
        logic pop_done;
        logic walk_eval;
        logic walk_done;
    } dda_cmd_t;

    typedef struct packed {
        logic need_pop;
        logic need_walk;
        logic out_free;
        logic walk_more;
        logic eval_replace;
    } dda_stat_t;

endpackage

/* design/dda_ram.sv */
module dda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/dda_ctrl.sv */
module dda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  dda_pkg::dda_stat_t  stat,
    output dda_pkg::dda_cmd_t   cmd
);

    dda_pkg::state_t state_reg;
    dda_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dda_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            dda_pkg::S_IDLE:
            begin
                req_ready = stat.out_free;
                if (req_valid && stat.out_free)
                begin
                    cmd.accept = 1'b1;
                    priority if (stat.need_pop)
                    begin
                        state_next = dda_pkg::S_POP;
                    end
                    else if (stat.need_walk)
                    begin
                        state_next = dda_pkg::S_WALK_CHECK;
                    end
                    else
                    begin
                        state_next = dda_pkg::S_IDLE;
                    end
                end
            end
            dda_pkg::S_POP:
            begin
                cmd.pop_done = 1'b1;
                state_next   = dda_pkg::S_IDLE;
            end
            dda_pkg::S_WALK_CHECK:
            begin
                if (stat.walk_more)
                begin
                    state_next = dda_pkg::S_WALK_EVAL;
                end
                else
                begin
                    cmd.walk_done = 1'b1;
                    state_next    = dda_pkg::S_IDLE;
                end
            end
            dda_pkg::S_WALK_EVAL:
            begin
                cmd.walk_eval = 1'b1;
                // a dropped entry pulls in the last one, examined at the same place
                state_next = stat.eval_replace ? dda_pkg::S_WALK_EVAL
                                               : dda_pkg::S_WALK_CHECK;
            end
            default:
            begin
                state_next = dda_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* design/dda_dp.sv */
module dda_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  dda_pkg::req_t      req,
    input  logic               rsp_ready,
    input  dda_pkg::dda_cmd_t  cmd,
    output dda_pkg::dda_stat_t stat,
    output dda_pkg::rsp_t      rsp,
    output logic               rsp_valid
);

    logic [dda_pkg::FCNT_W-1:0] free_count_reg, free_count_next;
    logic [dda_pkg::NF_W-1:0]   next_fresh_reg, next_fresh_next;
    logic [dda_pkg::PCNT_W-1:0] pending_count_reg, pending_count_next;
    logic [dda_pkg::PCNT_W-1:0] walk_pos_reg, walk_pos_next;
    logic [dda_pkg::MASK_W-1:0] retire_bit_reg, retire_bit_next;
    dda_pkg::status_t           walk_status_reg, walk_status_next;
    dda_pkg::rsp_t              rsp_reg, rsp_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    logic                        stack_we;
    logic [dda_pkg::SADDR_W-1:0] stack_waddr, stack_raddr;
    logic [dda_pkg::IDX_W-1:0]   stack_wdata, stack_rdata;

    logic                        pend_we;
    logic [dda_pkg::PADDR_W-1:0] pend_waddr, pend_raddr;
    dda_pkg::pend_entry_t        pend_wdata, pend_rd;
    logic [dda_pkg::PEND_W-1:0]  pend_rdata;

    logic                        reserved;
    logic                        open_ok;
    logic [dda_pkg::MASK_W-1:0]  free_mask;
    logic                        stack_full, pend_full;
    logic [dda_pkg::FCNT_W-1:0]  fc_dec;
    logic [dda_pkg::PCNT_W-1:0]  pc_dec;
    logic [dda_pkg::MASK_W-1:0]  eval_mask;
    logic                        eval_clear;
    logic                        has_last;

    dda_ram #(
        .WIDTH(dda_pkg::IDX_W),
        .DEPTH(dda_pkg::INDEX_SPACE)
    ) u_stack (
        .clk  (clk),
        .we   (stack_we),
        .waddr(stack_waddr),
        .wdata(stack_wdata),
        .raddr(stack_raddr),
        .rdata(stack_rdata)
    );

    dda_ram #(
        .WIDTH(dda_pkg::PEND_W),
        .DEPTH(dda_pkg::PENDING_DEPTH)
    ) u_pend (
        .clk  (clk),
        .we   (pend_we),
        .waddr(pend_waddr),
        .wdata(pend_wdata),
        .raddr(pend_raddr),
        .rdata(pend_rdata)
    );

    assign pend_rd = dda_pkg::pend_entry_t'(pend_rdata);

    assign reserved = (int'(req.index) < dda_pkg::RESERVED_COUNT)
                   || (int'(req.index) >= dda_pkg::INDEX_SPACE);
    assign open_ok  = req.frame_open && (int'(req.current_slot) < dda_pkg::FRAME_SLOTS);
    assign free_mask = (req.in_flight_mask & dda_pkg::SLOT_BITS)
                     | (open_ok ? (dda_pkg::MASK_W'(1) << req.current_slot)
                                : dda_pkg::MASK_W'(0));

    assign stack_full = free_count_reg == dda_pkg::FCNT_W'(dda_pkg::INDEX_SPACE);
    assign pend_full  = pending_count_reg == dda_pkg::PCNT_W'(dda_pkg::PENDING_DEPTH);
    assign fc_dec     = free_count_reg - dda_pkg::FCNT_W'(1);
    assign pc_dec     = pending_count_reg - dda_pkg::PCNT_W'(1);

    assign eval_mask  = pend_rd.mask & ~retire_bit_reg;
    assign eval_clear = eval_mask == '0;
    // another entry sits beyond the current position
    assign has_last   = walk_pos_reg < pc_dec;

    assign stat.need_pop     = (req.operation == dda_pkg::OP_ALLOC) && (free_count_reg != '0);
    assign stat.need_walk    = (req.operation == dda_pkg::OP_RETIRE)
                            && (int'(req.retire_slot) < dda_pkg::FRAME_SLOTS);
    assign stat.out_free     = !rsp_valid_reg || rsp_ready;
    assign stat.walk_more    = walk_pos_reg < pending_count_reg;
    assign stat.eval_replace = eval_clear && has_last;

    always_comb
    begin
        free_count_next    = free_count_reg;
        next_fresh_next    = next_fresh_reg;
        pending_count_next = pending_count_reg;
        walk_pos_next      = walk_pos_reg;
        retire_bit_next    = retire_bit_reg;
        walk_status_next   = walk_status_reg;
        rsp_next           = rsp_reg;
        rsp_valid_next     = rsp_valid_reg && !rsp_ready;

        stack_we    = 1'b0;
        stack_waddr = free_count_reg[dda_pkg::SADDR_W-1:0];
        stack_wdata = req.index;
        stack_raddr = fc_dec[dda_pkg::SADDR_W-1:0];

        pend_we    = 1'b0;
        pend_waddr = pending_count_reg[dda_pkg::PADDR_W-1:0];
        pend_wdata = '{index: req.index, mask: free_mask};
        pend_raddr = walk_pos_reg[dda_pkg::PADDR_W-1:0];

        if (cmd.accept)
        begin
            rsp_next.result_index = '0;
            rsp_next.status       = dda_pkg::ST_OK;
            rsp_valid_next        = !(stat.need_pop || stat.need_walk);
            unique case (req.operation)
                dda_pkg::OP_ALLOC:
                begin
                    if (free_count_reg != '0)
                    begin
                        // stack read is issued now, data shows up next cycle
                        free_count_next = fc_dec;
                    end
                    else if (next_fresh_reg < dda_pkg::NF_W'(dda_pkg::INDEX_SPACE))
                    begin
                        rsp_next.result_index = next_fresh_reg[dda_pkg::IDX_W-1:0];
                        next_fresh_next       = next_fresh_reg + dda_pkg::NF_W'(1);
                    end
                    else
                    begin
                        rsp_next.status = dda_pkg::ST_EXHAUSTED;
                    end
                end
                dda_pkg::OP_FREE:
                begin
                    if (reserved)
                    begin
                        rsp_next.status = dda_pkg::ST_IGNORED;
                    end
                    else if (free_mask == '0)
                    begin
                        if (stack_full)
                        begin
                            rsp_next.status = dda_pkg::ST_FULL;
                        end
                        else
                        begin
                            stack_we        = 1'b1;
                            free_count_next = free_count_reg + dda_pkg::FCNT_W'(1);
                        end
                    end
                    else if (pend_full)
                    begin
                        rsp_next.status = dda_pkg::ST_FULL;
                    end
                    else
                    begin
                        pend_we            = 1'b1;
                        pending_count_next = pending_count_reg + dda_pkg::PCNT_W'(1);
                    end
                end
                dda_pkg::OP_RETIRE:
                begin
                    walk_pos_next    = '0;
                    retire_bit_next  = dda_pkg::MASK_W'(1) << req.retire_slot;
                    walk_status_next = dda_pkg::ST_OK;
                end
                dda_pkg::OP_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.pop_done)
        begin
            rsp_next.result_index = stack_rdata;
            rsp_next.status       = dda_pkg::ST_OK;
            rsp_valid_next        = 1'b1;
        end

        if (cmd.walk_eval)
        begin
            if (eval_clear)
            begin
                stack_wdata = pend_rd.index;
                if (stack_full)
                begin
                    walk_status_next = dda_pkg::ST_FULL;
                end
                else
                begin
                    stack_we        = 1'b1;
                    free_count_next = free_count_reg + dda_pkg::FCNT_W'(1);
                end
                pending_count_next = pc_dec;
                // fetch the last entry to move into this position
                pend_raddr = pc_dec[dda_pkg::PADDR_W-1:0];
            end
            else
            begin
                pend_we       = 1'b1;
                pend_waddr    = walk_pos_reg[dda_pkg::PADDR_W-1:0];
                pend_wdata    = '{index: pend_rd.index, mask: eval_mask};
                walk_pos_next = walk_pos_reg + dda_pkg::PCNT_W'(1);
            end
        end

        if (cmd.walk_done)
        begin
            rsp_next.result_index = '0;
            rsp_next.status       = walk_status_reg;
            rsp_valid_next        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg    <= '0;
            next_fresh_reg    <= dda_pkg::NF_W'(dda_pkg::RESERVED_COUNT);
            pending_count_reg <= '0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            free_count_reg    <= free_count_next;
            next_fresh_reg    <= next_fresh_next;
            pending_count_reg <= pending_count_next;
            rsp_valid_reg     <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_pos_reg    <= walk_pos_next;
        retire_bit_reg  <= retire_bit_next;
        walk_status_reg <= walk_status_next;
        rsp_reg         <= rsp_next;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

/* design/deferred_descriptor_allocator.sv */
// free, no-op, fresh or exhausted allocate: result registered in the cycle after accept
// allocate from the free stack: accept issues the registered stack read, S_POP takes it
// retire: S_WALK_CHECK/S_WALK_EVAL visit the entries, one pending-memory port walks them
// one item at a time; the first kind can follow every cycle while results are taken
// reset clears free/pending counts and valid, presets next_fresh; both memories start undefined
module deferred_descriptor_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  dda_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output dda_pkg::rsp_t rsp
);

    dda_pkg::dda_cmd_t  cmd;
    dda_pkg::dda_stat_t stat;

    dda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dda_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp_ready(rsp_ready),
        .cmd      (cmd),
        .stat     (stat),
        .rsp      (rsp),
        .rsp_valid(rsp_valid)
    );

endmodule
